>>> rtl/mncp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIDI note capture block.
// Used by mncp_ctrl, mncp_dp and midi_note_capture_pairing; no dependencies.
package mncp_pkg;

    localparam int MNCP_TABLE_DEPTH = 64;
    localparam int MNCP_TIME_BITS   = 40;

    localparam int OP_W       = 3;
    localparam int NOTE_W     = 7;
    localparam int OFS_W      = 16;
    localparam int BLEN_W     = 16;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int CNT_OUT_W  = 7;
    localparam int DROP_W     = 16;
    localparam int OUT_TIME_W = 40;
    localparam int TAIL_W     = 20;

    localparam logic [TAIL_W-1:0] TAIL_RESET = 20'd24000;

    // input item: opcode, pitch, velocity, sample_offset, block_length, entry_index
    localparam int IN_FIELDS_W = OP_W + 2 * NOTE_W + OFS_W + BLEN_W + IDX_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // result item: status .. read_open
    localparam int OUT_FIELDS_W = STATUS_W + CNT_OUT_W + DROP_W + 4 * OUT_TIME_W
                                + 2 * NOTE_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON   = 3'd0,
        OP_NOTE_OFF  = 3'd1,
        OP_BLOCK_END = 3'd2,
        OP_START     = 3'd3,
        OP_STOP      = 3'd4,
        OP_READ      = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_NO_MATCH  = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLOSE,
        S_LENGTH,
        S_RDCAP,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    latch;        // capture input item
        logic    append;       // write new open entry
        logic    drop;         // count a dropped note-on
        logic    advance;      // position += block_length
        logic    start;        // begin take
        logic    stop;         // end take
        logic    scan_down;    // init newest-first scan
        logic    scan_up;      // init oldest-first scan
        logic    scan_run;     // scan active this cycle
        logic    close_write;  // close matched entry
        logic    len_load;     // take length <= running max
        logic    rd_issue;     // read entry at entry_index
        logic    rd_capture;   // latch read data into result
        logic    status_we;
        t_status status;
        logic    out_load;     // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_opcode op;
        logic    recording;
        logic    full;
        logic    vel_zero;
        logic    idx_bad;
        logic    match;
        logic    scan_idle;
        logic    out_free;
    } t_stat;

endpackage

>>> rtl/mncp_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM for the MIDI note capture block.
// Depends on mncp_pkg; drives mncp_dp through t_cmd, reads t_stat.
module mncp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mncp_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output mncp_pkg::t_cmd  o_cmd
);
    import mncp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_NOTE_ON, OP_NOTE_OFF: begin
                        if (i_stat.recording &&
                            (i_stat.op == OP_NOTE_OFF || i_stat.vel_zero)) begin
                            n_state = S_CLOSE;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    OP_STOP: n_state = i_stat.recording ? S_LENGTH : S_RESP;
                    OP_READ: n_state = i_stat.idx_bad ? S_RESP : S_RDCAP;
                    default: n_state = S_RESP;
                endcase
            end
            S_CLOSE: begin
                if (i_stat.match || i_stat.scan_idle) n_state = S_RESP;
            end
            S_LENGTH: begin
                if (i_stat.scan_idle) n_state = S_RESP;
            end
            S_RDCAP: n_state = S_RESP;
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.status_we = 1'b1;
                o_cmd.status    = ST_OK;
                unique case (i_stat.op) inside
                    OP_NOTE_ON, OP_NOTE_OFF: begin
                        if (!i_stat.recording) begin
                            o_cmd.status = ST_IGNORED;
                        end else if (i_stat.op == OP_NOTE_ON && !i_stat.vel_zero) begin
                            if (i_stat.full) begin
                                o_cmd.drop   = 1'b1;
                                o_cmd.status = ST_DROPPED;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end else begin
                            o_cmd.scan_down = 1'b1;
                        end
                    end
                    OP_BLOCK_END: begin
                        if (i_stat.recording) o_cmd.advance = 1'b1;
                        else o_cmd.status = ST_IGNORED;
                    end
                    OP_START: begin
                        if (i_stat.recording) o_cmd.status = ST_IGNORED;
                        else o_cmd.start = 1'b1;
                    end
                    OP_STOP: begin
                        if (i_stat.recording) begin
                            o_cmd.stop    = 1'b1;
                            o_cmd.scan_up = 1'b1;
                        end else begin
                            o_cmd.status = ST_IGNORED;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.idx_bad) o_cmd.status = ST_BAD_INDEX;
                        else o_cmd.rd_issue = 1'b1;
                    end
                    default: o_cmd.status = ST_IGNORED;
                endcase
            end
            S_CLOSE: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.match) begin
                    o_cmd.close_write = 1'b1;
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status      = ST_OK;
                end else if (i_stat.scan_idle) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_NO_MATCH;
                end
            end
            S_LENGTH: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.len_load = i_stat.scan_idle;
            end
            S_RDCAP: begin
                o_cmd.rd_capture = 1'b1;
            end
            S_RESP: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/mncp_dp.sv
`timescale 1ns / 1ps
// Datapath: note table memory, take counters, scan unit and output register.
// Depends on mncp_pkg; steered by mncp_ctrl through t_cmd.
module mncp_dp #(
    parameter int TABLE_DEPTH = mncp_pkg::MNCP_TABLE_DEPTH,
    parameter int TIME_BITS   = mncp_pkg::MNCP_TIME_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mncp_pkg::t_cmd                     i_cmd,
    output mncp_pkg::t_stat                    o_stat,
    input  logic [mncp_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic                               i_cfg_we,
    input  logic [mncp_pkg::TAIL_W-1:0]        i_cfg_wdata,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [mncp_pkg::OUT_TDATA_W-1:0]   o_out_data
);
    import mncp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = TIME_BITS;
    localparam int MW = 1 + 2 * NOTE_W + 2 * TW;

    // latched item
    t_opcode             r_op;
    logic [NOTE_W-1:0]   r_pitch;
    logic [NOTE_W-1:0]   r_vel;
    logic [OFS_W-1:0]    r_offset;
    logic [BLEN_W-1:0]   r_blen;
    logic [IDX_W-1:0]    r_idx;

    // take state
    logic [TAIL_W-1:0]   r_tail;
    logic [CW-1:0]       r_count;
    logic [TW-1:0]       r_pos;
    logic [DROP_W-1:0]   r_drop;
    logic                r_rec;
    logic [TW-1:0]       r_len;

    // result under construction
    t_status             r_status;
    logic [NOTE_W-1:0]   r_rd_pitch;
    logic [NOTE_W-1:0]   r_rd_vel;
    logic [TW-1:0]       r_rd_start;
    logic [TW-1:0]       r_rd_end;
    logic                r_rd_open;

    // scan unit
    logic [AW-1:0]       r_iss_addr;
    logic [CW-1:0]       r_iss_left;
    logic                r_scan_up;
    logic                r_rv;
    logic [AW-1:0]       r_rv_idx;
    logic [TW-1:0]       r_max;

    // note table
    logic [MW-1:0]       r_mem [TABLE_DEPTH];
    logic [MW-1:0]       r_mem_q;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [TW-1:0]       w_stamp;
    logic                w_q_open;
    logic [NOTE_W-1:0]   w_q_pitch;
    logic [NOTE_W-1:0]   w_q_vel;
    logic [TW-1:0]       w_q_start;
    logic [TW-1:0]       w_q_end;
    logic [TW-1:0]       w_q_len;
    logic [31:0]         w_idx32;
    logic [31:0]         w_cnt32;
    logic                w_idx_bad;
    logic                w_full;
    logic                w_issue;
    logic [AW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [MW-1:0]       w_wr_data;
    logic [CW-1:0]       w_cnt_m1;
    logic                w_out_free;
    logic [63:0]         w_len64;
    logic [63:0]         w_pos64;
    logic [63:0]         w_rs64;
    logic [63:0]         w_re64;

    assign w_stamp   = r_pos + TW'(r_offset);
    assign w_q_open  = r_mem_q[MW-1];
    assign w_q_pitch = r_mem_q[MW-2 -: NOTE_W];
    assign w_q_vel   = r_mem_q[MW-2-NOTE_W -: NOTE_W];
    assign w_q_start = r_mem_q[2*TW-1 -: TW];
    assign w_q_end   = r_mem_q[TW-1:0];
    assign w_q_len   = w_q_open ? (w_q_start + TW'(r_tail)) : w_q_end;

    assign w_idx32   = 32'(r_idx);
    assign w_cnt32   = 32'(r_count);
    assign w_idx_bad = (w_idx32 >= w_cnt32) || (w_idx32 >= 32'(TABLE_DEPTH));
    assign w_full    = (r_count == CW'(TABLE_DEPTH));
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_issue   = i_cmd.scan_run && (r_iss_left != '0);
    assign w_rd_addr = i_cmd.rd_issue ? w_idx32[AW-1:0] : r_iss_addr;

    assign w_wr_en   = i_cmd.append || i_cmd.close_write;
    assign w_wr_addr = i_cmd.close_write ? r_rv_idx : r_count[AW-1:0];
    assign w_wr_data = i_cmd.close_write
                     ? {1'b0, w_q_pitch, w_q_vel, w_q_start, w_stamp}
                     : {1'b1, r_pitch, r_vel, w_stamp, {TW{1'b0}}};

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat           = '0;
        o_stat.op        = r_op;
        o_stat.recording = r_rec;
        o_stat.full      = w_full;
        o_stat.vel_zero  = (r_vel == '0);
        o_stat.idx_bad   = w_idx_bad;
        o_stat.match     = r_rv && w_q_open && (w_q_pitch == r_pitch);
        o_stat.scan_idle = (r_iss_left == '0) && !r_rv;
        o_stat.out_free  = w_out_free;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_mem_q <= r_mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail      <= TAIL_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_drop      <= '0;
            r_rec       <= 1'b0;
            r_len       <= '0;
            r_iss_left  <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_tail <= i_cfg_wdata;
            if (i_cmd.append) r_count <= r_count + CW'(1);
            if (i_cmd.drop && r_drop != '1) r_drop <= r_drop + DROP_W'(1);
            if (i_cmd.advance) r_pos <= r_pos + TW'(r_blen);
            if (i_cmd.start) begin
                r_count <= '0;
                r_pos   <= '0;
                r_drop  <= '0;
                r_rec   <= 1'b1;
            end
            if (i_cmd.stop) r_rec <= 1'b0;
            if (i_cmd.len_load) r_len <= r_max;

            if (i_cmd.scan_down || i_cmd.scan_up) begin
                r_iss_left <= r_count;
            end else if (w_issue) begin
                r_iss_left <= r_iss_left - CW'(1);
            end
            r_rv <= w_issue;

            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= t_opcode'(i_in_data[2:0]);
            r_pitch    <= i_in_data[9:3];
            r_vel      <= i_in_data[16:10];
            r_offset   <= i_in_data[32:17];
            r_blen     <= i_in_data[48:33];
            r_idx      <= i_in_data[54:49];
            r_rd_pitch <= '0;
            r_rd_vel   <= '0;
            r_rd_start <= '0;
            r_rd_end   <= '0;
            r_rd_open  <= 1'b0;
        end
        if (i_cmd.status_we) r_status <= i_cmd.status;
        if (i_cmd.rd_capture) begin
            r_rd_pitch <= w_q_pitch;
            r_rd_vel   <= w_q_vel;
            r_rd_start <= w_q_start;
            r_rd_end   <= w_q_open ? '0 : w_q_end;
            r_rd_open  <= w_q_open;
        end

        if (i_cmd.scan_down) begin
            r_iss_addr <= w_cnt_m1[AW-1:0];
            r_scan_up  <= 1'b0;
        end else if (i_cmd.scan_up) begin
            r_iss_addr <= '0;
            r_scan_up  <= 1'b1;
            r_max      <= '0;
        end else if (w_issue) begin
            r_iss_addr <= r_scan_up ? (r_iss_addr + AW'(1)) : (r_iss_addr - AW'(1));
        end
        if (w_issue) r_rv_idx <= r_iss_addr;
        if (i_cmd.scan_run && r_scan_up && r_rv && (w_q_len > r_max)) r_max <= w_q_len;

        if (i_cmd.out_load) r_out_data <= {
            {OUT_PAD_W{1'b0}},
            r_rd_open,
            w_re64[OUT_TIME_W-1:0],
            w_rs64[OUT_TIME_W-1:0],
            r_rd_vel,
            r_rd_pitch,
            w_pos64[OUT_TIME_W-1:0],
            w_len64[OUT_TIME_W-1:0],
            r_drop,
            w_cnt32[CNT_OUT_W-1:0],
            r_status
        };
    end

    assign w_len64 = 64'(r_len);
    assign w_pos64 = 64'(r_pos);
    assign w_rs64  = 64'(r_rd_start);
    assign w_re64  = 64'(r_rd_end);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/midi_note_capture_pairing.sv
`timescale 1ns / 1ps
// MIDI note capture with immediate note pairing, top level.
// Depends on mncp_pkg, mncp_ctrl and mncp_dp.
//
// Usage:
//   Slave stream carries one event per item (note on/off, block end, start,
//   stop, read entry). Master stream returns exactly one result item per event.
//   i_cfg_we/i_cfg_wdata write tail_samples (reset value 24000); write only
//   while no event is in flight.
// Timing:
//   The block works on one event at a time. A simple event passes latch, decode
//   and result load from accept to result. A note-off walks the table
//   newest-first through the single read port of the note memory, one entry a
//   cycle, and stops at the first open entry of that pitch, or after the oldest
//   entry when none matches. A stop walks every stored entry oldest-first
//   through the same port. A read entry waits on the registered memory read.
//   The next event is taken as soon as the previous result sits in the output
//   register, even if the receiver has not taken it yet.
// Reset (synchronous, active low): not recording, table empty, counters and
//   take length zero. The table memory itself is not cleared; the fill count
//   keeps unwritten entries out of reach.
// Stall: with m_axis_tready low the result holds in the output register and
//   the block stops after finishing at most one further event.
module midi_note_capture_pairing #(
    parameter int TABLE_DEPTH = mncp_pkg::MNCP_TABLE_DEPTH,
    parameter int TIME_BITS   = mncp_pkg::MNCP_TIME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // opcode[2:0], pitch[9:3], velocity[16:10], sample_offset[32:17],
    // block_length[48:33], entry_index[54:49], zero pad above
    input  logic [mncp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // status[2:0], note_count[9:3], dropped_count[25:10], take_length[65:26],
    // stream_position[105:66], read_pitch[112:106], read_velocity[119:113],
    // read_start[159:120], read_end[199:160], read_open[200], zero pad above
    output logic [mncp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tail_samples register
    input  logic                             i_cfg_we,
    input  logic [mncp_pkg::TAIL_W-1:0]      i_cfg_wdata
);
    import mncp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mncp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    mncp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // one event in flight: after an accept the input side closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    // a dropped note-on only happens with the table full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_DROPPED)
        |-> m_axis_tdata[9:3] == 7'(TABLE_DEPTH))
        else $error("drop reported with free table slots");

    // read fields are zero unless the item was a successful read
    a_read_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)
        |-> !m_axis_tdata[200] && (m_axis_tdata[112:106] == '0)
            && (m_axis_tdata[159:120] == '0))
        else $error("stale read fields in result");

endmodule

>>> tb/sv/midi_note_capture_pairing_chk.sv
`timescale 1ns / 1ps
// Scoreboard for midi_note_capture_pairing: watches both streams and the tail
// register port, predicts each result item and compares it. Depends on mncp_pkg.
module midi_note_capture_pairing_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mncp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mncp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_we,
    input  logic [mncp_pkg::TAIL_W-1:0]      i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import mncp_pkg::*;

    localparam int AW = $clog2(MNCP_TABLE_DEPTH);

    // field order matches tdata, highest bits first
    typedef struct packed {
        logic [IDX_W-1:0]  entry_index;
        logic [BLEN_W-1:0] block_length;
        logic [OFS_W-1:0]  sample_offset;
        logic [NOTE_W-1:0] velocity;
        logic [NOTE_W-1:0] pitch;
        logic [OP_W-1:0]   opcode;
    } t_midi_event;

    typedef struct packed {
        logic                  rd_open;
        logic [OUT_TIME_W-1:0] rd_end;
        logic [OUT_TIME_W-1:0] rd_start;
        logic [NOTE_W-1:0]     rd_velocity;
        logic [NOTE_W-1:0]     rd_pitch;
        logic [OUT_TIME_W-1:0] position;
        logic [OUT_TIME_W-1:0] take_length;
        logic [DROP_W-1:0]     dropped;
        logic [CNT_OUT_W-1:0]  note_count;
        t_status               status;
    } t_capture_result;

    // shadow of the note table and take state
    logic [NOTE_W-1:0]     tbl_pitch    [MNCP_TABLE_DEPTH];
    logic [NOTE_W-1:0]     tbl_velocity [MNCP_TABLE_DEPTH];
    logic [OUT_TIME_W-1:0] tbl_start    [MNCP_TABLE_DEPTH];
    logic [OUT_TIME_W-1:0] tbl_end      [MNCP_TABLE_DEPTH];
    logic                  tbl_open     [MNCP_TABLE_DEPTH];
    logic [CNT_OUT_W-1:0]  fill;
    logic [OUT_TIME_W-1:0] position;
    logic [DROP_W-1:0]     drops;
    logic                  recording;
    logic [OUT_TIME_W-1:0] take_len;
    logic [TAIL_W-1:0]     tail;

    t_capture_result       want_q [$];
    t_capture_result       want, got;

    function automatic t_capture_result capture_event(input t_midi_event ev);
        t_capture_result       r;
        logic [OUT_TIME_W-1:0] stamp, span;
        logic [AW-1:0]         slot;
        int                    k;
        bit                    hit;
        r        = '0;
        r.status = ST_OK;
        stamp    = position + OUT_TIME_W'(ev.sample_offset);
        case (ev.opcode)
            OP_NOTE_ON, OP_NOTE_OFF: begin
                if (!recording) begin
                    r.status = ST_IGNORED;
                end else if (ev.opcode == OP_NOTE_ON && ev.velocity != '0) begin
                    if (fill == CNT_OUT_W'(MNCP_TABLE_DEPTH)) begin
                        if (drops != '1) drops++;
                        r.status = ST_DROPPED;
                    end else begin
                        slot               = AW'(fill);
                        tbl_pitch[slot]    = ev.pitch;
                        tbl_velocity[slot] = ev.velocity;
                        tbl_start[slot]    = stamp;
                        tbl_end[slot]      = '0;
                        tbl_open[slot]     = 1'b1;
                        fill++;
                    end
                end else begin
                    // note-off or zero-velocity note-on: newest open entry wins
                    hit = 1'b0;
                    for (k = int'(fill); k > 0; k--) begin
                        slot = AW'(k - 1);
                        if (!hit && tbl_open[slot] && tbl_pitch[slot] == ev.pitch) begin
                            tbl_end[slot]  = stamp;
                            tbl_open[slot] = 1'b0;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) r.status = ST_NO_MATCH;
                end
            end
            OP_BLOCK_END: begin
                if (!recording) r.status = ST_IGNORED;
                else position = position + OUT_TIME_W'(ev.block_length);
            end
            OP_START: begin
                if (recording) begin
                    r.status = ST_IGNORED;
                end else begin
                    fill      = '0;
                    position  = '0;
                    drops     = '0;
                    recording = 1'b1;
                end
            end
            OP_STOP: begin
                if (!recording) begin
                    r.status = ST_IGNORED;
                end else begin
                    recording = 1'b0;
                    take_len  = '0;
                    for (k = 0; k < int'(fill); k++) begin
                        slot = AW'(k);
                        span = tbl_open[slot] ? tbl_start[slot] + OUT_TIME_W'(tail)
                                              : tbl_end[slot];
                        if (span > take_len) take_len = span;
                    end
                end
            end
            OP_READ: begin
                if (CNT_OUT_W'(ev.entry_index) >= fill) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    slot          = AW'(ev.entry_index);
                    r.rd_pitch    = tbl_pitch[slot];
                    r.rd_velocity = tbl_velocity[slot];
                    r.rd_start    = tbl_start[slot];
                    r.rd_open     = tbl_open[slot];
                    r.rd_end      = tbl_open[slot] ? '0 : tbl_end[slot];
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        r.note_count  = fill;
        r.dropped     = drops;
        r.take_length = take_len;
        r.position    = position;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [OUT_TIME_W-1:0] exp_v,
                                        input logic [OUT_TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill      = '0;
            position  = '0;
            drops     = '0;
            recording = 1'b0;
            take_len  = '0;
            tail      = TAIL_RESET;
            want_q.delete();
            o_pending <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_FIELDS_W-1:0];
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = want_q.pop_front();
                    check_field("status", OUT_TIME_W'(want.status),
                                OUT_TIME_W'(got.status));
                    check_field("note_count", OUT_TIME_W'(want.note_count),
                                OUT_TIME_W'(got.note_count));
                    check_field("dropped_count", OUT_TIME_W'(want.dropped),
                                OUT_TIME_W'(got.dropped));
                    check_field("take_length", want.take_length, got.take_length);
                    check_field("stream_position", want.position, got.position);
                    check_field("read_pitch", OUT_TIME_W'(want.rd_pitch),
                                OUT_TIME_W'(got.rd_pitch));
                    check_field("read_velocity", OUT_TIME_W'(want.rd_velocity),
                                OUT_TIME_W'(got.rd_velocity));
                    check_field("read_start", want.rd_start, got.rd_start);
                    check_field("read_end", want.rd_end, got.rd_end);
                    check_field("read_open", OUT_TIME_W'(want.rd_open),
                                OUT_TIME_W'(got.rd_open));
                end
            end
            if (i_cfg_we) tail = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                want_q.insert(want_q.size(), capture_event(s_axis_tdata[IN_FIELDS_W-1:0]));
            o_pending <= want_q.size();
        end
    end

endmodule

>>> tb/sv/midi_note_capture_pairing_tb.sv
`timescale 1ns / 1ps
// Top of the midi_note_capture_pairing testbench: clock, reset, event stimulus,
// back-pressure and verdict. Depends on mncp_pkg, the block and midi_note_capture_pairing_chk.
module midi_note_capture_pairing_tb;
    import mncp_pkg::*;

    // opcodes the block has no use for; they must come back as ignored
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [TAIL_W-1:0] TAIL_MAX = '1;

    localparam int RANDOM_ITEMS = 1700;  // random part, spread over three phases
    localparam int HOLD_CYCLES  = 300;   // long receiver stall
    localparam int BIG_TAKE     = 220;   // enough note-ons to overflow the table
    localparam int SETTLE       = 80;    // > longest event (stop on full table)
    localparam int TIMEOUT_NS   = 6_000_000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [TAIL_W-1:0]      i_cfg_wdata   = '0;

    int chk_failures;
    int chk_pending;

    // idle percentages, changed per phase
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_req      = 1'b0;
    // items accepted so far; ends the random part
    int sent_items    = 0;

    always #1 i_clk = ~i_clk;

    midi_note_capture_pairing uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    midi_note_capture_pairing_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (chk_failures),
        .o_pending     (chk_pending)
    );

    // sized random field values
    function automatic logic [OP_W-1:0] rnd_op();
        return OP_W'($urandom_range(7));
    endfunction

    function automatic logic [NOTE_W-1:0] rnd_note();
        return NOTE_W'($urandom_range(127));
    endfunction

    function automatic logic [NOTE_W-1:0] rnd_vel();
        return NOTE_W'($urandom_range(1, 127));
    endfunction

    function automatic logic [OFS_W-1:0] rnd_ofs();
        return OFS_W'($urandom_range(65535));
    endfunction

    function automatic logic [BLEN_W-1:0] rnd_blen();
        return BLEN_W'($urandom_range(65535));
    endfunction

    function automatic logic [IDX_W-1:0] rnd_idx();
        return IDX_W'($urandom_range(63));
    endfunction

    // Offer one event, with random idle cycles in front of it. Returns at the
    // edge that took it; tvalid stays high so a following event goes back to back.
    task automatic send_event(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] pitch,
                              input logic [NOTE_W-1:0] vel, input logic [OFS_W-1:0] ofs,
                              input logic [BLEN_W-1:0] blen, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, idx, blen, ofs, vel, pitch, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    // only called right after drain() or after reset, with the block idle
    task automatic write_tail(input logic [TAIL_W-1:0] val);
        i_cfg_wdata <= val;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic pick_tail();
        case ($urandom_range(3))
            0:       write_tail('0);
            1:       write_tail(TAIL_MAX);
            default: write_tail(TAIL_W'($urandom_range(TAIL_MAX)));
        endcase
    endtask

    // One take: start, a mix of note traffic on a narrow pitch band so note-offs
    // find partners, block ends and reads, some noise, then stop and read back.
    task automatic run_take(input int n_events);
        logic [NOTE_W-1:0] band;
        logic [NOTE_W-1:0] vel;
        logic [IDX_W-1:0]  idx;
        int                k;
        int                dice;
        band = NOTE_W'($urandom_range(120));
        send_event(OP_START, rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), rnd_idx());
        for (k = 0; k < n_events; k++) begin
            dice = $urandom_range(99);
            idx  = $urandom_range(1) ? IDX_W'($urandom_range(15)) : rnd_idx();
            vel  = ($urandom_range(9) == 0) ? '0 : rnd_vel();
            if (dice < 38)
                send_event(OP_NOTE_ON, band + NOTE_W'($urandom_range(7)), vel,
                           rnd_ofs(), rnd_blen(), idx);
            else if (dice < 60)
                send_event(OP_NOTE_OFF, band + NOTE_W'($urandom_range(7)), rnd_note(),
                           rnd_ofs(), rnd_blen(), idx);
            else if (dice < 72)
                send_event(OP_BLOCK_END, rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), idx);
            else if (dice < 88)
                send_event(OP_READ, rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), idx);
            else if (dice < 93)
                // spare opcodes (ignored) and a start, ignored while still recording
                send_event(($urandom_range(2) == 0) ? OP_START :
                           ($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7),
                           rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), idx);
            else
                // fully random event, may break the take with an early stop
                send_event(rnd_op(), rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(),
                           rnd_idx());
        end
        send_event(OP_STOP, rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), rnd_idx());
        repeat ($urandom_range(1, 4))
            send_event(OP_READ, rnd_note(), rnd_note(), rnd_ofs(), rnd_blen(), rnd_idx());
    endtask

    // receiver: random ready, plus one long hold-off on request
    initial begin
        bit hold_seen;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[midi_note_capture_pairing] ERROR");
        $finish;
    end

    initial begin
        int phase;
        int target;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_tail(TAIL_MAX);

        // --- directed ---
        // not recording: note traffic, block end and stop are ignored
        send_event(OP_NOTE_ON,   7'd60,  7'd100, 16'd0,     16'd0,     6'd0);
        send_event(OP_NOTE_OFF,  7'd60,  7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_BLOCK_END, 7'd0,   7'd0,   16'd0,     16'd1000,  6'd0);
        send_event(OP_STOP,      7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        // empty table read, spare opcodes
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_SPARE_6,   7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_SPARE_7,   7'd127, 7'd127, 16'hFFFF,  16'hFFFF,  6'd63);
        // start, then a second start while recording
        send_event(OP_START,     7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_START,     7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        // field extremes on note-on
        send_event(OP_NOTE_ON,   7'd127, 7'd127, 16'hFFFF,  16'd0,     6'd0);
        send_event(OP_NOTE_ON,   7'd0,   7'd1,   16'd0,     16'd0,     6'd0);
        send_event(OP_BLOCK_END, 7'd0,   7'd0,   16'd0,     16'hFFFF,  6'd0);
        // note-off with nothing open at that pitch
        send_event(OP_NOTE_OFF,  7'd5,   7'd0,   16'd12,    16'd0,     6'd0);
        // zero-velocity note-on closes pitch 127
        send_event(OP_NOTE_ON,   7'd127, 7'd0,   16'd100,   16'd0,     6'd0);
        // second pitch 0 note; the note-off must close this newer one
        send_event(OP_NOTE_ON,   7'd0,   7'd64,  16'hFFFF,  16'd0,     6'd0);
        send_event(OP_NOTE_OFF,  7'd0,   7'd127, 16'd7,     16'd0,     6'd0);
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd1);
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd2);
        // index past the fill count
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd63);
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd3);
        send_event(OP_BLOCK_END, 7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        // stop with one note still held: max tail credited
        send_event(OP_STOP,      7'd0,   7'd0,   16'd0,     16'd0,     6'd0);
        send_event(OP_READ,      7'd0,   7'd0,   16'd0,     16'd0,     6'd1);
        send_event(OP_STOP,      7'd0,   7'd0,   16'd0,     16'd0,     6'd0);

        // --- random takes in three idle phases ---
        for (phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin
                    src_idle_pct  = 21;
                    sink_idle_pct = 69;
                    write_tail('0);
                end
                1: begin
                    src_idle_pct  = 69;
                    sink_idle_pct = 21;
                    write_tail(TAIL_W'($urandom_range(TAIL_MAX)));
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    write_tail(TAIL_MAX);
                    // receiver stalls while the sender keeps pushing
                    hold_req = 1'b1;
                end
            endcase
            target = sent_items + RANDOM_ITEMS / 3;
            while (sent_items < target) begin
                run_take(($urandom_range(4) == 0) ? BIG_TAKE : $urandom_range(4, 40));
                if ($urandom_range(3) == 0) begin
                    drain();
                    pick_tail();
                end
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (chk_failures == 0)
            $display("[midi_note_capture_pairing] OK");
        else
            $display("[midi_note_capture_pairing] ERROR");
        $finish;
    end

endmodule
